/* sv/lcg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared sizes, register codes and stage types of the Life generation stream.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int DIM_W     = $clog2(MAX_COLUMNS + 1);
  localparam int NROW_W    = $clog2(MAX_ROWS + 1);
  localparam int ROW_W     = $clog2(MAX_ROWS + 2);
  localparam int CMP_W     = ((ROW_W > DIM_W) ? ROW_W : DIM_W) + 1;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int DATA_W    = 8;

  localparam int DIM_RESET = 64;
  localparam int DIM_MIN   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_COLUMNS = 2'd0,
    CFG_BOARD_ROWS    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             interior;
    logic             bot;
    logic [COL_W-1:0] col;
  } tag_t;

endpackage

/* sv/life_cell_generation_stream_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cell_generation_stream_unit
// One generation of Life (B3/S23) over a raster-streamed board, one cell a
// clock while output is free; two line stores, a 3x3 neighborhood window.
//
//   channel   dir  handshake               payload
//   s_axis    in   s_axis_tvalid/tready    tdata[0] cell, tuser mode
//   m_axis    out  m_axis_tvalid/tready    tdata[0] next cell, tlast frame end
//   cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// one cell per clock sustained unless the output stalls; the line store read
// adds one register stage beside the tag stage that feeds the output register
// each result leaves one row plus one cell after its input
// reset clears counters, window and valids; line stores keep no reset
// a stalled output holds an emitting tag stage, which then holds the input side
// ----------------------------------------------------------------------------
module life_cell_generation_stream_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lcg_pkg::DATA_W-1:0]   s_axis_tdata,  // [0] cell_in_alive
  input  logic                         s_axis_tuser,  // [0] mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lcg_pkg::DATA_W-1:0]   m_axis_tdata,  // [0] cell_out_alive
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [lcg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lcg_pkg::CFG_W-1:0]    cfg_wdata_i
);
  import lcg_pkg::*;

  cfg_wr_t          cfg;
  tag_t             tag;
  logic [COL_W-1:0] rd_col;
  logic             accept;
  logic             s1_valid_q;
  logic             s1_adv;
  logic             top_rd, mid_rd;
  logic             alive;
  logic             cfg_hit;
  logic             out_valid_q;
  logic             out_alive_q;
  logic             out_last_q;

  assign cfg     = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_wdata_i};
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CFG_BOARD_COLUMNS ||
                                cfg_idx_i == CFG_BOARD_ROWS);

  assign s1_adv        = s1_valid_q && (!tag.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lcg_raster_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (accept),
    .cell_i   (s_axis_tdata[0]),
    .mode_i   (s_axis_tuser),
    .tag_o    (tag),
    .rd_col_o (rd_col)
  );

  lcg_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_upper_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (tag.col),
    .wdata_i (mid_rd),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (top_rd)
  );

  lcg_ram #(.WIDTH(1), .DEPTH(MAX_COLUMNS)) u_middle_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (tag.col),
    .wdata_i (tag.bot),
    .re_i    (accept),
    .raddr_i (rd_col),
    .rdata_o (mid_rd)
  );

  lcg_window_core u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_hit),
    .adv_i   (s1_adv),
    .tag_i   (tag),
    .top_i   (top_rd),
    .mid_i   (mid_rd),
    .alive_o (alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && tag.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && tag.emit) begin
      out_alive_q <= alive;
      out_last_q  <= tag.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(DATA_W-1){1'b0}}, out_alive_q};
  assign m_axis_tlast  = out_last_q;

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && tag.emit |=> m_axis_tvalid)
    else $error("emitting cell did not reach the output register");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

  a_ready_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready)
    else $error("input not ready with an empty tag stage");

endmodule

/* sv/lcg_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lcg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/lcg_raster_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_raster_ctrl
// Board size registers, raster position counters and per-cell tag decode.
// ----------------------------------------------------------------------------
module lcg_raster_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcg_pkg::cfg_wr_t         cfg_i,
  input  logic                     accept_i,
  input  logic                     cell_i,
  input  logic                     mode_i,
  output lcg_pkg::tag_t            tag_o,
  output logic [lcg_pkg::COL_W-1:0] rd_col_o
);
  import lcg_pkg::*;

  logic [DIM_W-1:0]  ncol_q;
  logic [NROW_W-1:0] nrow_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  tag_t              tag_q, tag_d;
  logic              cfg_hit;
  logic              c_nz;
  logic [ROW_W-1:0]  orow;
  logic [DIM_W-1:0]  ocol;
  logic [CMP_W-1:0]  orow_x, ocol_x, ncol_x, nrow_x, col_x;

  function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (v < CFG_W'(DIM_MIN)) r = CFG_W'(DIM_MIN);
    else if (v > hi) r = hi;
    return r;
  endfunction

  assign cfg_hit = cfg_i.we && (cfg_i.idx == CFG_BOARD_COLUMNS ||
                                cfg_i.idx == CFG_BOARD_ROWS);

  always_comb begin
    c_nz   = (col_q != '0);
    orow   = c_nz ? (row_q - ROW_W'(1)) : (row_q - ROW_W'(2));
    ocol   = c_nz ? (DIM_W'(col_q) - DIM_W'(1)) : (ncol_q - DIM_W'(1));
    orow_x = CMP_W'(orow);
    ocol_x = CMP_W'(ocol);
    ncol_x = CMP_W'(ncol_q);
    nrow_x = CMP_W'(nrow_q);
    col_x  = CMP_W'(col_q);

    tag_d.emit     = c_nz ? (row_q >= ROW_W'(1)) : (row_q >= ROW_W'(2));
    tag_d.interior = (orow_x != '0) && (orow_x + CMP_W'(2) <= nrow_x) &&
                     (ocol_x != '0) && (ocol_x + CMP_W'(2) <= ncol_x);
    tag_d.last     = tag_d.emit && (orow_x + CMP_W'(1) == nrow_x) &&
                     (ocol_x + CMP_W'(1) == ncol_x);
    tag_d.bot      = cell_i & ~mode_i;
    tag_d.col      = col_q;

    if (tag_d.last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_x + CMP_W'(1) >= ncol_x) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncol_q <= DIM_W'(DIM_RESET);
      nrow_q <= NROW_W'(DIM_RESET);
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CFG_BOARD_COLUMNS: ncol_q <= DIM_W'(clamp_dim(cfg_i.data, CFG_W'(MAX_COLUMNS)));
        CFG_BOARD_ROWS:    nrow_q <= NROW_W'(clamp_dim(cfg_i.data, CFG_W'(MAX_ROWS)));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_hit) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      tag_q <= tag_d;
    end
  end

  assign tag_o    = tag_q;
  assign rd_col_o = col_q;

  a_col_in_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(col_q) < CMP_W'(ncol_q))
    else $error("column counter beyond board width");

  a_row_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(row_q) <= CMP_W'(nrow_q) + CMP_W'(1))
    else $error("row counter beyond board tail");

  a_frame_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && tag_d.last |=> col_q == '0 && row_q == '0)
    else $error("counters did not restart after final cell");

endmodule

/* sv/lcg_window_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_window_core
// Neighborhood window, neighbor count and B3/S23 rule for one cell.
// ----------------------------------------------------------------------------
module lcg_window_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clear_i,
  input  logic          adv_i,
  input  lcg_pkg::tag_t tag_i,
  input  logic          top_i,
  input  logic          mid_i,
  output logic          alive_o
);
  import lcg_pkg::*;

  // bit 0 top row, bit 1 middle row, bit 2 bottom row
  logic [2:0] w1_q, w1_d;
  logic [2:0] w2_q, w2_d;
  logic [3:0] nbr;
  logic       center;
  logic       rule;

  always_comb begin
    center = w2_q[1];
    nbr = 4'(w1_q[0]) + 4'(w1_q[1]) + 4'(w1_q[2]) + 4'(w2_q[0]) +
          4'(w2_q[2]) + 4'(top_i) + 4'(mid_i) + 4'(tag_i.bot);
    rule    = center ? (nbr == 4'd2 || nbr == 4'd3) : (nbr == 4'd3);
    alive_o = tag_i.interior ? rule : center;

    if (tag_i.last) begin
      w1_d = '0;
      w2_d = '0;
    end else begin
      w1_d = w2_q;
      w2_d = {tag_i.bot, mid_i, top_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (clear_i) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (adv_i) begin
      w1_q <= w1_d;
      w2_q <= w2_d;
    end
  end

endmodule

/* sim/life_cell_generation_stream_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cell_generation_stream_unit_tb
// Streams Life boards through the unit and checks every next-generation cell
// and frame end against an in-bench B3/S23 line-store model. Covers the reset
// board size, clamped and ignored register writes, early drains, tail cells,
// mid-frame restarts and clamped tall boards, under random stalls on both sides.
// ----------------------------------------------------------------------------
module life_cell_generation_stream_unit_tb;
  import lcg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_WAIT      = 20000;

  typedef struct packed {
    logic alive;
    logic last;
  } next_cell_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic                 s_axis_tuser = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // board model state
  logic             upper_store [MAX_COLUMNS] = '{default: 1'b0};
  logic             middle_store [MAX_COLUMNS] = '{default: 1'b0};
  logic [2:0]       win_col [3] = '{default: 3'b000};  // [0] top, [1] mid, [2] bottom
  int unsigned      in_col = 0;
  int unsigned      in_row = 0;
  logic [CFG_W-1:0] cols_reg = CFG_W'(DIM_RESET);
  logic [CFG_W-1:0] rows_reg = CFG_W'(DIM_RESET);

  next_cell_t  next_gen_q [$];
  int unsigned src_idle_pct = 34;
  int unsigned sink_idle_pct = 51;
  int unsigned mismatches = 0;
  int unsigned cells_sent = 0;
  int unsigned results_seen = 0;
  int unsigned boards_done = 0;
  int unsigned cycles = 0;

  life_cell_generation_stream_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [0] cell_in_alive
    .s_axis_tuser  (s_axis_tuser),   // [0] mode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] cell_out_alive
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (32'(v) < 32'(DIM_MIN)) return DIM_MIN;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  function automatic void restart_board();
    win_col = '{default: 3'b000};
    in_col = 0;
    in_row = 0;
  endfunction

  // advance the board by one accepted cell, queue the next-generation cell it releases
  function automatic void step_life_board(input logic cell_bit, input logic drain);
    int unsigned ncol, nrow, r, c, orow, ocol, n;
    logic        top, mid, bot, alive, last, emit;
    ncol = clamp_dim(cols_reg, MAX_COLUMNS);
    nrow = clamp_dim(rows_reg, MAX_ROWS);
    r = in_row;
    c = (in_col >= ncol) ? 0 : in_col;
    bot = drain ? 1'b0 : cell_bit;
    top = upper_store[c];
    mid = middle_store[c];
    emit = 1'b0;
    last = 1'b0;
    orow = 0;
    ocol = 0;
    if (c >= 1 && r >= 1) begin
      orow = r - 1;
      ocol = c - 1;
      emit = 1'b1;
    end else if (c == 0 && r >= 2) begin
      orow = r - 2;
      ocol = ncol - 1;
      emit = 1'b1;
    end
    if (emit) begin
      alive = win_col[2][1];
      if (orow >= 1 && orow + 2 <= nrow && ocol >= 1 && ocol + 2 <= ncol) begin
        n = $countones({win_col[1], win_col[2][0], win_col[2][2], top, mid, bot});
        alive = win_col[2][1] ? (n == 2 || n == 3) : (n == 3);
      end
      last = (orow + 1 == nrow) && (ocol + 1 == ncol);
      next_gen_q.push_back('{alive: alive, last: last});
    end
    win_col[0] = win_col[1];
    win_col[1] = win_col[2];
    win_col[2] = {bot, mid, top};
    upper_store[c] = mid;
    middle_store[c] = bot;
    if (c + 1 >= ncol) begin
      in_col = 0;
      in_row = r + 1;
    end else begin
      in_col = c + 1;
    end
    if (last) restart_board();
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    if ($urandom_range(9) == 0) return CFG_W'($urandom_range(2));
    return CFG_W'($urandom_range(3, 9));
  endfunction

  task automatic send_cell(input logic cell_bit, input logic drain);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(DATA_W-1){1'b0}}, cell_bit};
    s_axis_tuser  <= drain;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    step_life_board(cell_bit, drain);
    cells_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (next_gen_q.size() != 0);
  endtask

  task automatic settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BOARD_COLUMNS: begin
        cols_reg = value;
        restart_board();
      end
      CFG_BOARD_ROWS: begin
        rows_reg = value;
        restart_board();
      end
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one board in raster order plus its drain tail, cut short at stop_at
  task automatic send_frame(input int unsigned density, input int unsigned stop_at);
    int unsigned ncol, nrow, cells, k;
    logic        cell_bit, drain;
    ncol = clamp_dim(cols_reg, MAX_COLUMNS);
    nrow = clamp_dim(rows_reg, MAX_ROWS);
    cells = ncol * nrow;
    for (k = 0; k < stop_at && k < cells + ncol + 1; k++) begin
      if (k == cells / 2 && $urandom_range(3) == 0) wait_for_results();
      if (k < cells) begin
        cell_bit = ($urandom_range(99) < density);
        drain    = ($urandom_range(99) < 3);
      end else begin
        cell_bit = 1'($urandom_range(1));
        drain    = 1'($urandom_range(1));
      end
      send_cell(cell_bit, drain);
    end
  endtask

  task automatic test_default_board();
    send_frame(40, 140);
  endtask

  // 3x3 boards: live center with two neighbors and an early-drained bottom row,
  // then a crowded center that dies, each followed by mixed tail cells
  task automatic test_directed_boards();
    logic [12:0] cells [2];
    logic [12:0] drains [2];
    int          b, k;
    cells[0]  = 13'b0011111010011;
    drains[0] = 13'b1010111000000;
    cells[1]  = 13'b1100111111111;
    drains[1] = 13'b0101000000000;
    settle();
    write_reg(CFG_BOARD_COLUMNS, 11'd1);
    write_reg(CFG_BOARD_ROWS, 11'd0);
    write_reg(CFG_SPARE_LO, 11'd5);
    write_reg(CFG_SPARE_HI, 11'h7ff);
    for (b = 0; b < 2; b++) begin
      for (k = 0; k < 13; k++) begin
        if (b == 0 && k == 5) wait_for_results();
        send_cell(cells[b][k], drains[b][k]);
      end
    end
  endtask

  task automatic test_random_boards(input int unsigned budget);
    int unsigned sent, ncol, len, stop_at;
    logic        must_restart;
    sent = 0;
    must_restart = 1'b1;
    while (sent < budget) begin
      if (must_restart || $urandom_range(2) == 0) begin
        settle();
        if ($urandom_range(5) == 0) begin
          write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom_range(2047)));
        end
        write_reg(CFG_BOARD_COLUMNS, pick_dim());
        write_reg(CFG_BOARD_ROWS, pick_dim());
        must_restart = 1'b0;
      end
      ncol = clamp_dim(cols_reg, MAX_COLUMNS);
      len = ncol * clamp_dim(rows_reg, MAX_ROWS) + ncol + 1;
      stop_at = len;
      if ($urandom_range(7) == 0) begin
        stop_at = $urandom_range(1, len - 1);
        must_restart = 1'b1;
      end
      send_frame($urandom_range(15, 70), stop_at);
      sent += stop_at;
    end
  endtask

  task automatic test_extreme_boards();
    settle();
    write_reg(CFG_BOARD_COLUMNS, 11'd3);
    write_reg(CFG_BOARD_ROWS, 11'h7ff);
    send_frame(50, 80);
    settle();
    write_reg(CFG_BOARD_COLUMNS, 11'd4);
    write_reg(CFG_BOARD_ROWS, 11'd1024);
    send_frame(50, 60);
  endtask

  // result checker, sampled on the falling edge ahead of the transfer edge
  always @(negedge clk_i) begin
    next_cell_t exp_cell;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tlast) boards_done++;
      if (next_gen_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected transfer: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        end
        mismatches++;
      end else begin
        exp_cell = next_gen_q.pop_front();
        if (m_axis_tdata !== {{(DATA_W-1){1'b0}}, exp_cell.alive} ||
            m_axis_tlast !== exp_cell.last) begin
          if (mismatches < 10) begin
            $display("result %0d: expected tdata %h tlast %b, got tdata %h tlast %b",
                     results_seen, {{(DATA_W-1){1'b0}}, exp_cell.alive}, exp_cell.last,
                     m_axis_tdata, m_axis_tlast);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_board();
    test_directed_boards();
    test_random_boards(100);

    src_idle_pct  = 51;
    sink_idle_pct = 34;
    test_random_boards(100);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_boards(100);
    test_extreme_boards();

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (next_gen_q.size() != 0 && guard < END_WAIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (next_gen_q.size() != 0) begin
      $display("%0d next-generation cells never arrived", next_gen_q.size());
      mismatches += next_gen_q.size();
    end

    $display("run covered %0d cell transfers, %0d next-generation cells, %0d complete boards",
             cells_sent, results_seen, boards_done);
    $display("boards from 3x3 up to clamped 1024-row boards, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* life_cell_generation_stream_unit.f */
sv/lcg_pkg.sv
sv/lcg_ram.sv
sv/lcg_raster_ctrl.sv
sv/lcg_window_core.sv
sv/life_cell_generation_stream_unit.sv
sim/life_cell_generation_stream_unit_tb.sv
